@@ rtl/esckd_pkg.sv @@
// shared types and constants for the escape sequence key decoder
// used by esckd_ctrl, esckd_fifo, esckd_dp and escape_sequence_key_decoder
// no dependencies
package esckd_pkg;

  // default sizes
  localparam int FIFO_DEPTH_DEF = 64;
  localparam int ESC_MAX_DEF    = 4;

  // field widths
  localparam int KEY_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int TIME_W     = 64;
  localparam int TMO_W      = 32;
  localparam int PEND_W     = 7;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // stream packing
  localparam int IN_TDATA_W  = 80;  // byte, start, time = 73 bits, padded
  localparam int OUT_TDATA_W = 24;  // key, pending, overflow

  // request kinds
  localparam logic [CMD_W-1:0] CMD_RX    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CHECK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN    = 2'd2;

  // register reset values
  localparam logic [TMO_W-1:0] TIMEOUT_RST = 32'd200000000;
  localparam logic [KEY_W-1:0] UP_RST      = 16'd72;
  localparam logic [KEY_W-1:0] DOWN_RST    = 16'd80;

  // sequence characters
  localparam logic [BYTE_W-1:0] ESC_CHAR = 8'h1B;
  localparam logic [BYTE_W-1:0] LBRACKET = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_UP    = 8'h41;
  localparam logic [BYTE_W-1:0] CH_DOWN  = 8'h42;
  localparam int                SEQ_LEN  = 3;

  // push source select
  localparam logic [1:0] PUSH_RX   = 2'd0;
  localparam logic [1:0] PUSH_ESC  = 2'd1;
  localparam logic [1:0] PUSH_UP   = 2'd2;
  localparam logic [1:0] PUSH_DOWN = 2'd3;

  typedef struct packed {
    logic       load_in;
    logic       collect;
    logic       clear_esc;
    logic       rel_start;
    logic       rel_inc;
    logic       push;
    logic [1:0] push_sel;
    logic       pop;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic esc_empty;
    logic esc_hit;
    logic flush;
    logic match_up;
    logic match_down;
    logic rel_last;
  } dp_status_t;

endpackage

@@ rtl/escape_sequence_key_decoder.sv @@
// console key decoder top level: stream ports, controller and datapath
// one request per step, one result per request; rate is set by the controller,
// which handles one request at a time: idle, then a check state per timeout check (a
// collected byte gets one), a release state per raw byte released, a receive state for
// a byte, a pop state for a pop, and done; releases write the queue one byte a cycle;
// rst (synchronous, active high) empties the queue, drops any partial sequence and
// restores the register defaults; the queue memory needs no clearing pass
module escape_sequence_key_decoder import esckd_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
  parameter int ESC_MAX    = ESC_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // request stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // rx_byte, message_start, now_ns
  input  logic [CMD_W-1:0]       s_axis_tuser,   // command
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // key_code, pending_keys, overflow
  output logic                   m_axis_tuser,   // key_valid
  // register writes
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // request fields
  logic [BYTE_W-1:0] in_byte;
  logic              in_start;
  logic [TIME_W-1:0] in_now;

  assign in_byte  = s_axis_tdata[BYTE_W-1:0];
  assign in_start = s_axis_tdata[BYTE_W];
  assign in_now   = s_axis_tdata[BYTE_W+TIME_W:BYTE_W+1];

  // controller to datapath
  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // result register contents
  logic [KEY_W-1:0]  key_code;
  logic              key_valid;
  logic [PEND_W-1:0] pending_keys;
  logic              overflow;

  esckd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_cmd    (s_axis_tuser),
    .in_start  (in_start),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  esckd_dp #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .ESC_MAX    (ESC_MAX)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_byte      (in_byte),
    .in_now       (in_now),
    .cmd          (cmd),
    .sts          (sts),
    .key_code     (key_code),
    .key_valid    (key_valid),
    .pending_keys (pending_keys),
    .overflow     (overflow)
  );

  // result packing, lowest field first
  assign m_axis_tdata = {overflow, pending_keys, key_code};
  assign m_axis_tuser = key_valid;

endmodule

@@ rtl/esckd_ctrl.sv @@
// sequencing state machine for the escape sequence key decoder
// depends on esckd_pkg
module esckd_ctrl import esckd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic             in_start,
  output logic             out_valid,
  input  logic             out_ready,
  input  dp_status_t       sts,
  output ctrl_cmd_t        cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CHECK   = 3'd1;
  localparam logic [2:0] S_RELEASE = 3'd2;
  localparam logic [2:0] S_RECV    = 3'd3;
  localparam logic [2:0] S_POP     = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0] state, state_next;
  logic [2:0] ret_state, ret_state_next;

  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    cmd            = '0;
    in_ready       = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          priority if (in_cmd == CMD_RX && in_start) begin
            state_next     = S_CHECK;
            ret_state_next = S_RECV;
          end else if (in_cmd == CMD_RX) begin
            state_next = S_RECV;
          end else if (in_cmd == CMD_CHECK) begin
            state_next     = S_CHECK;
            ret_state_next = S_DONE;
          end else if (in_cmd == CMD_POP) begin
            state_next     = S_CHECK;
            ret_state_next = S_POP;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_CHECK: begin
        priority if (sts.esc_empty) begin
          state_next = ret_state;
        end else if (sts.flush) begin
          cmd.rel_start = 1'b1;
          state_next    = S_RELEASE;
        end else if (sts.match_up) begin
          cmd.push      = 1'b1;
          cmd.push_sel  = PUSH_UP;
          cmd.clear_esc = 1'b1;
          state_next    = ret_state;
        end else if (sts.match_down) begin
          cmd.push      = 1'b1;
          cmd.push_sel  = PUSH_DOWN;
          cmd.clear_esc = 1'b1;
          state_next    = ret_state;
        end else begin
          state_next = ret_state;
        end
      end
      S_RELEASE: begin
        cmd.push     = 1'b1;
        cmd.push_sel = PUSH_ESC;
        if (sts.rel_last) begin
          cmd.clear_esc = 1'b1;
          state_next    = ret_state;
        end else begin
          cmd.rel_inc = 1'b1;
        end
      end
      S_RECV: begin
        if (sts.esc_hit) begin
          cmd.collect    = 1'b1;
          state_next     = S_CHECK;
          ret_state_next = S_DONE;
        end else begin
          cmd.push     = 1'b1;
          cmd.push_sel = PUSH_RX;
          state_next   = S_DONE;
        end
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_state <= S_DONE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/esckd_fifo.sv @@
// key queue: circular buffer in a memory with registered read data
// depends on esckd_pkg
module esckd_fifo import esckd_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [KEY_W-1:0]           push_data,
  input  logic                       pop,
  output logic [KEY_W-1:0]           rd_data,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic                       full,
  output logic                       empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [KEY_W-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic             push_ok, pop_ok;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= push_data;
    end
    if (pop_ok) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop_ok) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      count <= count + CW'(push_ok) - CW'(pop_ok);
    end
  end

endmodule

@@ rtl/esckd_dp.sv @@
// datapath: config registers, escape collection, timeout compare, output register
// depends on esckd_pkg and esckd_fifo
module esckd_dp import esckd_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
  parameter int ESC_MAX    = ESC_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [BYTE_W-1:0]     in_byte,
  input  logic [TIME_W-1:0]     in_now,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            sts,
  output logic [KEY_W-1:0]      key_code,
  output logic                  key_valid,
  output logic [PEND_W-1:0]     pending_keys,
  output logic                  overflow
);

  localparam int ECW = $clog2(ESC_MAX + 1);
  localparam int IW  = $clog2(ESC_MAX);
  localparam int CW  = $clog2(FIFO_DEPTH + 1);

  logic [TMO_W-1:0]  esc_timeout_ns;
  logic [KEY_W-1:0]  up_key_code, down_key_code;

  logic [BYTE_W-1:0] rx_byte;
  logic [TIME_W-1:0] now_ns;
  logic [BYTE_W-1:0] esc_bytes [ESC_MAX];
  logic [ECW-1:0]    esc_count;
  logic [TIME_W-1:0] esc_time;
  logic [IW-1:0]     rel_idx;
  logic              dropped;
  logic              pop_hit;

  logic [TIME_W:0]   limit;
  logic              expired;
  logic              seq_head;
  logic [KEY_W-1:0]  push_data;
  logic [KEY_W-1:0]  rd_data;
  logic [CW-1:0]     fifo_count;
  logic              fifo_full, fifo_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_timeout_ns <= TIMEOUT_RST;
      up_key_code    <= UP_RST;
      down_key_code  <= DOWN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMEOUT: esc_timeout_ns <= cfg_data[TMO_W-1:0];
        CFG_UP:      up_key_code    <= cfg_data[KEY_W-1:0];
        CFG_DOWN:    down_key_code  <= cfg_data[KEY_W-1:0];
        default:     ;
      endcase
    end
  end

  // no-wrap timeout compare: a carry out never expires
  assign limit   = {1'b0, esc_time} + {{(TIME_W + 1 - TMO_W){1'b0}}, esc_timeout_ns};
  assign expired = !limit[TIME_W] && (limit[TIME_W-1:0] <= now_ns);

  assign seq_head = (esc_count == ECW'(SEQ_LEN)) && (esc_bytes[0] == ESC_CHAR) &&
                    (esc_bytes[1] == LBRACKET);

  always_comb begin
    sts.esc_empty  = (esc_count == '0);
    sts.esc_hit    = ((esc_count != '0) || (rx_byte == ESC_CHAR)) &&
                     (esc_count < ECW'(ESC_MAX));
    sts.flush      = expired || (esc_count >= ECW'(ESC_MAX));
    sts.match_up   = seq_head && (esc_bytes[2] == CH_UP);
    sts.match_down = seq_head && (esc_bytes[2] == CH_DOWN);
    sts.rel_last   = (ECW'(rel_idx) + 1'b1 == esc_count);
  end

  always_comb begin
    unique case (cmd.push_sel)
      PUSH_RX:   push_data = {{(KEY_W - BYTE_W){1'b0}}, rx_byte};
      PUSH_ESC:  push_data = {{(KEY_W - BYTE_W){1'b0}}, esc_bytes[rel_idx]};
      PUSH_UP:   push_data = up_key_code;
      PUSH_DOWN: push_data = down_key_code;
      default:   push_data = '0;
    endcase
  end

  esckd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd.push),
    .push_data (push_data),
    .pop       (cmd.pop),
    .rd_data   (rd_data),
    .count     (fifo_count),
    .full      (fifo_full),
    .empty     (fifo_empty)
  );

  // collected bytes, request payload, release index and output register
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rx_byte <= in_byte;
      now_ns  <= in_now;
    end
    if (cmd.collect) begin
      esc_bytes[esc_count[IW-1:0]] <= rx_byte;
    end
    if (cmd.rel_start) begin
      rel_idx <= '0;
    end else if (cmd.rel_inc) begin
      rel_idx <= rel_idx + 1'b1;
    end
    if (cmd.out_load) begin
      key_code     <= pop_hit ? rd_data : '0;
      key_valid    <= pop_hit;
      pending_keys <= PEND_W'(fifo_count);
      overflow     <= dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_count <= '0;
      esc_time  <= '0;
      dropped   <= 1'b0;
      pop_hit   <= 1'b0;
    end else begin
      if (cmd.clear_esc) begin
        esc_count <= '0;
      end else if (cmd.collect) begin
        esc_count <= esc_count + 1'b1;
        esc_time  <= now_ns;
      end
      if (cmd.load_in) begin
        dropped <= 1'b0;
      end else if (cmd.push && fifo_full) begin
        dropped <= 1'b1;
      end
      if (cmd.load_in) begin
        pop_hit <= 1'b0;
      end else if (cmd.pop && !fifo_empty) begin
        pop_hit <= 1'b1;
      end
    end
  end

endmodule

@@ dv/esckd_checker.sv @@
`timescale 1ns / 100ps
// result checker for escape_sequence_key_decoder: predicts every result and compares it
// depends on esckd_pkg; watches the request, result and register write ports
module esckd_checker import esckd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // rx_byte, message_start, now_ns
  input  logic [CMD_W-1:0]       s_axis_tuser,   // command
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // key_code, pending_keys, overflow
  input  logic                   m_axis_tuser,   // key_valid
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     results_owed
);

  localparam int KEYQ_DEPTH = FIFO_DEPTH_DEF;
  localparam int SEQ_MAX    = ESC_MAX_DEF;
  localparam int PRINT_CAP  = 200;

  typedef struct packed {
    logic [KEY_W-1:0]  key_code;
    logic              key_valid;
    logic [PEND_W-1:0] pending_keys;
    logic              overflow;
  } key_result_t;

  logic [TMO_W-1:0]  tmo_ns;
  logic [KEY_W-1:0]  up_code;
  logic [KEY_W-1:0]  down_code;
  logic [BYTE_W-1:0] seq_bytes [SEQ_MAX];
  int                seq_len;
  logic [TIME_W-1:0] seq_time;
  logic [KEY_W-1:0]  keyq [KEYQ_DEPTH];
  int                keyq_head;
  int                keyq_count;
  bit                keyq_dropped;
  key_result_t       owed_results [$];

  initial mismatches = 0;
  initial results_owed = 0;

  function automatic void keyq_push(logic [KEY_W-1:0] v);
    if (keyq_count >= KEYQ_DEPTH) begin
      keyq_dropped = 1'b1;
    end else begin
      keyq[(keyq_head + keyq_count) % KEYQ_DEPTH] = v;
      keyq_count++;
    end
  endfunction

  // timeout / length release first, then arrow matching
  function automatic void resolve_seq(logic [TIME_W-1:0] now_ns);
    logic [TIME_W:0] deadline;
    if (seq_len == 0) return;
    deadline = {1'b0, seq_time} + {{(TIME_W-TMO_W+1){1'b0}}, tmo_ns};
    if (deadline <= {1'b0, now_ns} || seq_len >= SEQ_MAX) begin
      for (int i = 0; i < seq_len; i++) keyq_push({{(KEY_W-BYTE_W){1'b0}}, seq_bytes[i]});
      seq_len = 0;
    end else if (seq_len == SEQ_LEN && seq_bytes[0] == ESC_CHAR && seq_bytes[1] == LBRACKET) begin
      if (seq_bytes[2] == CH_UP) begin
        keyq_push(up_code);
        seq_len = 0;
      end else if (seq_bytes[2] == CH_DOWN) begin
        keyq_push(down_code);
        seq_len = 0;
      end
    end
  endfunction

  function automatic key_result_t predict_key_result(logic [CMD_W-1:0] cmd,
      logic [BYTE_W-1:0] rx, logic start, logic [TIME_W-1:0] now_ns);
    key_result_t r;
    r = '0;
    keyq_dropped = 1'b0;
    case (cmd)
      CMD_RX: begin
        if (start) resolve_seq(now_ns);
        if ((seq_len != 0 || rx == ESC_CHAR) && seq_len < SEQ_MAX) begin
          seq_bytes[seq_len] = rx;
          seq_len++;
          seq_time = now_ns;
          resolve_seq(now_ns);
        end else begin
          keyq_push({{(KEY_W-BYTE_W){1'b0}}, rx});
        end
      end
      CMD_CHECK: resolve_seq(now_ns);
      CMD_POP: begin
        resolve_seq(now_ns);
        if (keyq_count != 0) begin
          r.key_code  = keyq[keyq_head];
          r.key_valid = 1'b1;
          keyq_head   = (keyq_head + 1) % KEYQ_DEPTH;
          keyq_count--;
        end
      end
      default: ;
    endcase
    r.pending_keys = PEND_W'(keyq_count);
    r.overflow     = keyq_dropped;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
    if (mismatches < PRINT_CAP)
      $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    key_result_t got;
    key_result_t want;
    if (rst) begin
      tmo_ns     = TIMEOUT_RST;
      up_code    = UP_RST;
      down_code  = DOWN_RST;
      seq_len    = 0;
      seq_time   = '0;
      keyq_head  = 0;
      keyq_count = 0;
      owed_results.delete();
      results_owed <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMEOUT: tmo_ns = cfg_data[TMO_W-1:0];
          CFG_UP:      up_code = cfg_data[KEY_W-1:0];
          CFG_DOWN:    down_code = cfg_data[KEY_W-1:0];
          default: ;
        endcase
      end
      // results first: a request accepted on this edge cannot answer on it
      if (m_axis_tvalid && m_axis_tready) begin
        got.key_code     = m_axis_tdata[KEY_W-1:0];
        got.pending_keys = m_axis_tdata[KEY_W +: PEND_W];
        got.overflow     = m_axis_tdata[KEY_W+PEND_W];
        got.key_valid    = m_axis_tuser;
        if (owed_results.size() == 0) begin
          report_mismatch("result with no request", got.key_code, '0);
        end else begin
          want = owed_results.pop_front();
          if (got.key_code !== want.key_code)
            report_mismatch("key_code", got.key_code, want.key_code);
          if (got.key_valid !== want.key_valid)
            report_mismatch("key_valid", KEY_W'(got.key_valid), KEY_W'(want.key_valid));
          if (got.pending_keys !== want.pending_keys)
            report_mismatch("pending_keys", KEY_W'(got.pending_keys), KEY_W'(want.pending_keys));
          if (got.overflow !== want.overflow)
            report_mismatch("overflow", KEY_W'(got.overflow), KEY_W'(want.overflow));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        owed_results.push_back(predict_key_result(s_axis_tuser, s_axis_tdata[BYTE_W-1:0],
            s_axis_tdata[BYTE_W], s_axis_tdata[BYTE_W+1 +: TIME_W]));
      results_owed <= owed_results.size();
    end
  end

endmodule

@@ dv/tb_escape_sequence_key_decoder.sv @@
`timescale 1ns / 100ps
// top of the escape_sequence_key_decoder testbench: clock, reset, stimulus and verdict
// depends on esckd_pkg, escape_sequence_key_decoder and esckd_checker
module tb_escape_sequence_key_decoder;
  import esckd_pkg::*;

  // command 3 is unused by the block and must only report the queue level
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 65;
  localparam int BURST_ITEMS = 70;
  localparam int HOLD_CYCLES = 250;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // rx_byte, message_start, now_ns
  logic [CMD_W-1:0]       s_axis_tuser = '0;   // command
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // key_code, pending_keys, overflow
  logic                   m_axis_tuser;        // key_valid
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int                mismatches;
  int                results_owed;
  int                send_idle_pct = 0;   // chance per cycle that the sender holds back
  int                recv_stall_pct = 0;  // chance per cycle that the receiver stalls
  int                hold_left = 0;       // long receiver hold-off, counted down below
  int                sent = 0;
  int                cycle_count = 0;
  logic [TIME_W-1:0] clock_ns = '0;       // console time carried in every request

  escape_sequence_key_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  esckd_checker key_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .results_owed  (results_owed)
  );

  always #10 clk = ~clk;

  // receiver: random stalls, or a long hold-off when the stimulus asks for one
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one request: optional idle gap, then hold valid until the block takes it;
  // valid is left high on return so back-to-back requests never toggle it
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] rx, logic start,
      logic [TIME_W-1:0] now_ns);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W-TIME_W-BYTE_W-1){1'b0}}, now_ns, start, rx};
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  // drop valid and wait for every owed result; the owed counter is registered in the checker
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // all three registers on consecutive edges, write enable held throughout
  task automatic load_settings(logic [TMO_W-1:0] tmo, logic [KEY_W-1:0] up,
      logic [KEY_W-1:0] down);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= tmo;
    @(posedge clk);
    cfg_index <= CFG_UP;
    cfg_data  <= CFG_DATA_W'(up);
    @(posedge clk);
    cfg_index <= CFG_DOWN;
    cfg_data  <= CFG_DATA_W'(down);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // ESC [ <last> with short gaps so the timeout normally does not cut it
  task automatic send_arrow(logic [BYTE_W-1:0] last);
    send_request(CMD_RX, ESC_CHAR, 1'($urandom), clock_ns);
    clock_ns += $urandom_range(1, 2000);
    send_request(CMD_RX, LBRACKET, 1'($urandom), clock_ns);
    clock_ns += $urandom_range(1, 2000);
    send_request(CMD_RX, last, 1'($urandom), clock_ns);
  endtask

  // mostly small steps; some jumps past the default timeout, some past the
  // largest timeout, and a few arbitrary 64-bit times to reach the wrap case
  task automatic step_time();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80)
      clock_ns += $urandom_range(1, 4000);
    else if (pick < 92)
      clock_ns += $urandom_range(0, 400000000);
    else if (pick < 97)
      clock_ns += {$urandom_range(0, 3), $urandom};
    else
      clock_ns = {$urandom, $urandom};
  endtask

  // one random unit of traffic, mostly well-formed arrow sequences and pops
  task automatic random_burst();
    int pick;
    pick = $urandom_range(0, 99);
    step_time();
    if (pick < 30) begin
      // mostly a real arrow, sometimes a near miss on the final byte
      send_arrow($urandom_range(0, 9) == 0 ? 8'($urandom) :
                 ($urandom_range(0, 1) ? CH_UP : CH_DOWN));
    end else if (pick < 38) begin
      // broken sequence: ESC plus a few bytes that may or may not fit
      send_request(CMD_RX, ESC_CHAR, 1'($urandom), clock_ns);
      repeat ($urandom_range(0, 3)) begin
        clock_ns += $urandom_range(1, 3000);
        send_request(CMD_RX, $urandom_range(0, 1) ? LBRACKET : 8'($urandom),
                     1'($urandom), clock_ns);
      end
    end else if (pick < 55) begin
      send_request(CMD_RX, 8'($urandom), 1'($urandom), clock_ns);
    end else if (pick < 87) begin
      send_request(CMD_POP, 8'($urandom), 1'($urandom), clock_ns);
    end else if (pick < 94) begin
      send_request(CMD_CHECK, 8'($urandom), 1'($urandom), clock_ns);
    end else if (pick < 97) begin
      send_request(CMD_NONE, 8'($urandom), 1'($urandom), clock_ns);
    end else begin
      // noise: every field random, command 3 included
      send_request(CMD_W'($urandom), 8'($urandom), 1'($urandom), {$urandom, $urandom});
    end
  endtask

  task automatic run_phase(int p);
    int first;
    bit mid_done;
    first    = sent;
    mid_done = 1'b0;
    while (sent - first < PHASE_ITEMS) begin
      random_burst();
      if (!mid_done && sent - first >= PHASE_ITEMS / 2) begin
        mid_done = 1'b1;
        if (p == 1) begin
          // back-pressure: receiver blocked while the sender streams plain bytes,
          // enough to overflow the key queue, then pops to drain it
          send_idle_pct = 0;
          hold_left = HOLD_CYCLES;
          repeat (BURST_ITEMS) begin
            clock_ns += $urandom_range(1, 4000);
            send_request(CMD_RX, 8'($urandom_range(32, 126)), 1'b0, clock_ns);
          end
          repeat (BURST_ITEMS) send_request(CMD_POP, 8'($urandom), 1'b0, clock_ns);
          send_idle_pct = 54;
        end
        if (p == 2)
          wait_drained();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, reset register values, no idling on either side
    clock_ns = 64'd1000;
    send_request(CMD_POP, 8'h00, 1'b0, clock_ns);                // pop on empty queue
    send_request(CMD_RX, 8'h00, 1'b0, clock_ns);                 // plain bytes, extremes
    send_request(CMD_RX, 8'hFF, 1'b1, clock_ns);
    send_arrow(CH_UP);
    send_arrow(CH_DOWN);
    // unmatched three-byte sequence, fourth byte forces a raw release of all four
    send_arrow(8'h43);
    send_request(CMD_RX, 8'h78, 1'b0, clock_ns);
    // lone ESC released exactly when the timeout is reached
    clock_ns = 64'd20000;
    send_request(CMD_RX, ESC_CHAR, 1'b0, clock_ns);
    send_request(CMD_CHECK, 8'h00, 1'b0, clock_ns + 64'(TIMEOUT_RST));
    // deadline past the top of 64-bit time never expires
    send_request(CMD_RX, ESC_CHAR, 1'b0, 64'hFFFF_FFFF_FFFF_FF00);
    send_request(CMD_CHECK, 8'h00, 1'b0, '1);
    // message start runs the check first, then the byte joins the sequence
    clock_ns = 64'd5000;
    send_request(CMD_RX, 8'h71, 1'b1, clock_ns);
    send_request(CMD_CHECK, 8'h00, 1'b0, clock_ns + 64'(TIMEOUT_RST));
    send_request(CMD_NONE, 8'hA5, 1'b1, clock_ns);
    repeat (8) send_request(CMD_POP, 8'h00, 1'b0, clock_ns);
    wait_drained();

    // random phases, each with its own register set and idling profile
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: load_settings('0, '0, '1);
        1: load_settings('1, '1, '0);
        2: load_settings(TMO_W'($urandom_range(500, 50000)), 16'($urandom), 16'($urandom));
        default: load_settings(TIMEOUT_RST, 16'($urandom), 16'($urandom));
      endcase
      send_idle_pct  = (p == 1) ? 54 : (p == 3) ? 13 : 0;
      recv_stall_pct = (p == 2) ? 54 : (p == 3) ? 13 : 0;
      run_phase(p);
      wait_drained();
      // settle time for the controller before touching the registers again
      repeat (20) @(posedge clk);
    end

    recv_stall_pct = 0;
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
